// ----- rtl/bmf_pkg.sv -----
// Box mean filter: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package bmf_pkg;
    localparam int CHAN_BITS  = 8;
    localparam int PIX_BITS   = 3 * CHAN_BITS;
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = 13;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 13;

    localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_AW-1:0] REG_HALF_WIDTH   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_HALF_HEIGHT  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_COLOR_MODE   = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_ACC  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;
endpackage

// ----- rtl/bmf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bmf_ram #(
    parameter int DW    = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/bmf_div.sv -----
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on bmf_pkg.
`timescale 1ns / 1ps
module bmf_div #(
    parameter int NW = 16,
    parameter int DW = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [NW-1:0]                  i_num,
    input  logic [DW-1:0]                  i_den,
    output logic [bmf_pkg::CHAN_BITS-1:0]  o_quo,
    output logic                           o_done
);
    localparam int QW = bmf_pkg::CHAN_BITS;
    localparam int SW = $clog2(QW);

    logic [NW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [SW-1:0] r_step;
    logic          r_busy;
    logic [NW-1:0] trial;

    assign trial = NW'(r_den) << r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_den  <= i_den;
                r_step <= SW'(QW - 1);
                o_quo  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_rem >= trial) begin
                    r_rem         <= r_rem - trial;
                    o_quo[r_step] <= 1'b1;
                end
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end
endmodule

// ----- rtl/box_mean_filter_core.sv -----
// Box mean filter top level: counters, row memory, window sweep, output beat.
// Depends on bmf_pkg, bmf_ram, bmf_div.
//
// channel  | valid     | ready     | payload
// input    | i_valid   | o_ready   | i_chan0_in, i_chan1_in, i_chan2_in, i_is_filler
// output   | o_valid   | i_ready   | o_chan0_out .. o_chan2_out, o_passed_through, o_frame_done
// config   | i_cfg_we  | -         | i_cfg_addr, i_cfg_data
//
// An input beat that yields no result is taken in S_IDLE alone. One that yields a result
// makes (2*hh+1)*(2*hw+1) memory reads (1 for a border pixel) through the single
// read port in S_SUM, then passes S_ACC and the dividers in S_DIV, then the output beat.
// Reset is synchronous; the row memory needs no clearing. o_ready is low while
// a result is computed or waits on i_ready.
`timescale 1ns / 1ps
module box_mean_filter_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bmf_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [bmf_pkg::CFG_DW-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_chan0_in,
    input  logic [7:0]                    i_chan1_in,
    input  logic [7:0]                    i_chan2_in,
    input  logic                          i_is_filler,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_chan0_out,
    output logic [7:0]                    o_chan1_out,
    output logic [7:0]                    o_chan2_out,
    output logic                          o_passed_through,
    output logic                          o_frame_done
);
    localparam int SLOTS = 2 * MAX_RADIUS + 2;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int KW    = $clog2(2 * MAX_RADIUS + 1);
    localparam int DEPTH = SLOTS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int HW    = bmf_pkg::ROW_W;
    localparam int TW    = HW + CW;
    localparam int CNTW  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SUMW  = CNTW + bmf_pkg::CHAN_BITS;
    localparam int CB    = bmf_pkg::CHAN_BITS;

    bmf_pkg::t_state r_state;

    logic [10:0] r_fw;
    logic [12:0] r_fh;
    logic [2:0]  r_hwr, r_hhr;
    logic        r_cm;

    logic [CW-1:0] w;
    logic [HW-1:0] h;
    logic [RW-1:0] hw, hh;
    logic [TW-1:0] total, lag;

    logic [HW-1:0] r_in_row, r_out_row;
    logic [CW-1:0] r_in_col, r_out_col;
    logic [SW-1:0] r_in_slot, r_out_slot;
    logic [TW-1:0] r_in_cnt, r_out_cnt;

    logic [SW-1:0]   r_ys;
    logic [KW-1:0]   r_yk, r_ylast, r_xk, r_xlast;
    logic [CW-1:0]   r_xs, r_xc;
    logic [SUMW-1:0] r_sum0, r_sum1, r_sum2;
    logic [CNTW-1:0] r_cnt;
    logic            r_rdv, r_start, r_bord, r_done, r_cm_q;

    logic                      acc, full, wr, last_pix, emit, border, done;
    logic                      cfg_hit;
    logic [CW-1:0]             col_nx;
    logic [SW-1:0]             slot_nx, ys_start;
    logic [TW-1:0]             cnt_nx;
    logic [AW-1:0]             waddr, raddr;
    logic [bmf_pkg::PIX_BITS-1:0] rdata;
    logic [CB-1:0]             q0, q1, q2;
    logic                      d0, d1, d2;

    always_comb begin
        if (r_fw == '0) begin
            w = CW'(1);
        end else if (32'(r_fw) > MAX_WIDTH) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(r_fw);
        end
        if (r_fh == '0) begin
            h = HW'(1);
        end else if (32'(r_fh) > bmf_pkg::MAX_HEIGHT) begin
            h = HW'(bmf_pkg::MAX_HEIGHT);
        end else begin
            h = HW'(r_fh);
        end
        hw = (32'(r_hwr) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_hwr);
        hh = (32'(r_hhr) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_hhr);
    end

    assign total = TW'(w) * TW'(h);
    assign lag   = TW'(hh) * TW'(w) + TW'(hw);

    assign o_ready  = (r_state == bmf_pkg::S_IDLE);
    assign o_valid  = (r_state == bmf_pkg::S_OUT);
    assign acc      = i_valid && o_ready;
    assign full     = (r_in_row >= h);
    assign wr       = !full && !i_is_filler;
    assign cnt_nx   = r_in_cnt + 1'b1;
    assign last_pix = (cnt_nx == total);
    assign emit     = full || (wr && (last_pix || (cnt_nx - r_out_cnt > lag)));
    assign done     = (r_out_cnt + 1'b1 == total);
    assign col_nx   = r_in_col + 1'b1;
    assign slot_nx  = (32'(r_in_slot) == SLOTS - 1) ? '0 : r_in_slot + 1'b1;
    assign ys_start = (r_out_slot >= SW'(hh)) ? r_out_slot - SW'(hh)
                                              : r_out_slot + SW'(SLOTS) - SW'(hh);
    assign cfg_hit  = i_cfg_we && (i_cfg_addr <= bmf_pkg::REG_COLOR_MODE);

    assign border = (32'(r_out_row) < 32'(hh))
                 || (32'(r_out_row) + 32'(hh) >= 32'(h))
                 || (32'(r_out_col) < 32'(hw))
                 || (32'(r_out_col) + 32'(hw) >= 32'(w));

    assign waddr = AW'(r_in_slot) * AW'(MAX_WIDTH) + AW'(r_in_col);
    assign raddr = AW'(r_ys) * AW'(MAX_WIDTH) + AW'(r_xc);

    bmf_ram #(.DW(bmf_pkg::PIX_BITS), .DEPTH(DEPTH)) u_rows (
        .i_clk   (i_clk),
        .i_we    (acc && wr),
        .i_waddr (waddr),
        .i_wdata ({i_chan2_in, i_chan1_in, i_chan0_in}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    bmf_div #(.NW(SUMW), .DW(CNTW)) u_div0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_num(r_sum0), .i_den(r_cnt), .o_quo(q0), .o_done(d0)
    );
    bmf_div #(.NW(SUMW), .DW(CNTW)) u_div1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_num(r_sum1), .i_den(r_cnt), .o_quo(q1), .o_done(d1)
    );
    bmf_div #(.NW(SUMW), .DW(CNTW)) u_div2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_num(r_sum2), .i_den(r_cnt), .o_quo(q2), .o_done(d2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bmf_pkg::S_IDLE;
            r_fw       <= 11'd640;
            r_fh       <= 13'd480;
            r_hwr      <= 3'd1;
            r_hhr      <= 3'd1;
            r_cm       <= 1'b0;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_in_cnt   <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_slot <= '0;
            r_out_cnt  <= '0;
            r_rdv      <= 1'b0;
            r_start    <= 1'b0;
        end else begin
            r_rdv   <= 1'b0;
            r_start <= 1'b0;
            if (r_rdv) begin
                r_sum0 <= r_sum0 + SUMW'(rdata[CB-1:0]);
                r_sum1 <= r_sum1 + SUMW'(rdata[2*CB-1:CB]);
                r_sum2 <= r_sum2 + SUMW'(rdata[3*CB-1:2*CB]);
            end
            unique case (r_state)
                bmf_pkg::S_IDLE: begin
                    if (acc) begin
                        if (wr) begin
                            r_in_cnt <= cnt_nx;
                            if (col_nx == w) begin
                                r_in_col  <= '0;
                                r_in_row  <= r_in_row + 1'b1;
                                r_in_slot <= slot_nx;
                            end else begin
                                r_in_col <= col_nx;
                            end
                        end
                        if (emit) begin
                            r_sum0 <= '0;
                            r_sum1 <= '0;
                            r_sum2 <= '0;
                            r_bord <= border;
                            r_done <= done;
                            r_cm_q <= r_cm;
                            r_yk   <= '0;
                            r_xk   <= '0;
                            if (border) begin
                                r_ys    <= r_out_slot;
                                r_xs    <= r_out_col;
                                r_xc    <= r_out_col;
                                r_ylast <= '0;
                                r_xlast <= '0;
                                r_cnt   <= CNTW'(1);
                            end else begin
                                r_ys    <= ys_start;
                                r_xs    <= r_out_col - CW'(hw);
                                r_xc    <= r_out_col - CW'(hw);
                                r_ylast <= KW'({hh, 1'b0});
                                r_xlast <= KW'({hw, 1'b0});
                                r_cnt   <= CNTW'((CNTW'({hh, 1'b1})) * (CNTW'({hw, 1'b1})));
                            end
                            if (done) begin
                                r_in_row   <= '0;
                                r_in_col   <= '0;
                                r_in_slot  <= '0;
                                r_in_cnt   <= '0;
                                r_out_row  <= '0;
                                r_out_col  <= '0;
                                r_out_slot <= '0;
                                r_out_cnt  <= '0;
                            end else begin
                                r_out_cnt <= r_out_cnt + 1'b1;
                                if (r_out_col + 1'b1 == w) begin
                                    r_out_col  <= '0;
                                    r_out_row  <= r_out_row + 1'b1;
                                    r_out_slot <= (32'(r_out_slot) == SLOTS - 1) ? '0
                                                : r_out_slot + 1'b1;
                                end else begin
                                    r_out_col <= r_out_col + 1'b1;
                                end
                            end
                            r_state <= bmf_pkg::S_SUM;
                        end
                    end
                end
                bmf_pkg::S_SUM: begin
                    r_rdv <= 1'b1;
                    if (r_xk == r_xlast) begin
                        r_xk <= '0;
                        r_xc <= r_xs;
                        r_yk <= r_yk + 1'b1;
                        r_ys <= (32'(r_ys) == SLOTS - 1) ? '0 : r_ys + 1'b1;
                        if (r_yk == r_ylast) begin
                            r_state <= bmf_pkg::S_ACC;
                        end
                    end else begin
                        r_xk <= r_xk + 1'b1;
                        r_xc <= r_xc + 1'b1;
                    end
                end
                bmf_pkg::S_ACC: begin
                    r_start <= 1'b1;
                    r_state <= bmf_pkg::S_DIV;
                end
                bmf_pkg::S_DIV: begin
                    if (d0 && d1 && d2) begin
                        o_chan0_out      <= q0;
                        o_chan1_out      <= r_cm_q ? q1 : '0;
                        o_chan2_out      <= r_cm_q ? q2 : '0;
                        o_passed_through <= r_bord;
                        o_frame_done     <= r_done;
                        r_state          <= bmf_pkg::S_OUT;
                    end
                end
                bmf_pkg::S_OUT: begin
                    if (i_ready) begin
                        r_state <= bmf_pkg::S_IDLE;
                    end
                end
                default: r_state <= bmf_pkg::S_IDLE;
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    bmf_pkg::REG_FRAME_WIDTH:  r_fw  <= i_cfg_data[10:0];
                    bmf_pkg::REG_FRAME_HEIGHT: r_fh  <= i_cfg_data[12:0];
                    bmf_pkg::REG_HALF_WIDTH:   r_hwr <= i_cfg_data[2:0];
                    bmf_pkg::REG_HALF_HEIGHT:  r_hhr <= i_cfg_data[2:0];
                    bmf_pkg::REG_COLOR_MODE:   r_cm  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                r_in_row   <= '0;
                r_in_col   <= '0;
                r_in_slot  <= '0;
                r_in_cnt   <= '0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_out_slot <= '0;
                r_out_cnt  <= '0;
            end
        end
    end
endmodule

// ----- test/tb.sv -----
// Testbench for box_mean_filter_core: directed and random frames checked by a
// scoreboard that recomputes every filtered pixel.
// Depends on bmf_pkg and box_mean_filter_core.
`timescale 1ns / 1ps
module tb;
    import bmf_pkg::*;

    localparam int LIMIT = 3000000;
    localparam int SETTLE = 300;
    localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       border;
        logic       last;
    } pix_res_t;

    class MeanScoreboard;
        logic [23:0] line_mem [16*1024];
        logic [10:0] fw;
        logic [12:0] fh;
        logic [2:0]  hw;
        logic [2:0]  hh;
        logic        rgb;
        int unsigned row, col, ocount;
        pix_res_t    pending[$];
        int          errors;
        bit          frame_end;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            fw = 640; fh = 480; hw = 1; hh = 1; rgb = 0;
            row = 0; col = 0; ocount = 0; errors = 0; frame_end = 0;
        endfunction

        function int unsigned width_used();
            return (fw == 0) ? 1 : (fw > 1024) ? 1024 : fw;
        endfunction

        function int unsigned height_used();
            return (fh == 0) ? 1 : (fh > MAX_HEIGHT) ? MAX_HEIGHT : fh;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] a, logic [CFG_DW-1:0] d);
            case (a)
                REG_FRAME_WIDTH:  fw = d[10:0];
                REG_FRAME_HEIGHT: fh = d[12:0];
                REG_HALF_WIDTH:   hw = d[2:0];
                REG_HALF_HEIGHT:  hh = d[2:0];
                REG_COLOR_MODE:   rgb = d[0];
                default:          return;
            endcase
            row = 0; col = 0; ocount = 0;
        endfunction

        function void note_input(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                 logic filler);
            int unsigned w, h, total, lag, got, r, c, cnt;
            int unsigned s [3];
            logic [23:0] p;
            pix_res_t e;
            bit edge_pix;
            w = width_used();
            h = height_used();
            total = w * h;
            lag = hh * w + hw;
            if (row >= h) begin
                row = h;
                col = 0;
            end
            if (col >= w) col = 0;
            if (ocount >= total) ocount = 0;
            if (row < h) begin
                if (filler) return;
                line_mem[(row % 16) * 1024 + col] = {c2, c1, c0};
                col++;
                if (col == w) begin
                    col = 0;
                    row++;
                end
            end
            got = (row >= h) ? total : row * w + col;
            if (row < h && got - ocount <= lag) return;
            r = ocount / w;
            c = ocount % w;
            edge_pix = (r < hh) || (r + hh >= h) || (c < hw) || (c + hw >= w);
            s[0] = 0; s[1] = 0; s[2] = 0;
            if (edge_pix) begin
                p = line_mem[(r % 16) * 1024 + c];
                for (int k = 0; k < 3; k++) s[k] = p[8*k +: 8];
            end else begin
                cnt = (2 * hh + 1) * (2 * hw + 1);
                for (int y = r - hh; y <= r + hh; y++)
                    for (int x = c - hw; x <= c + hw; x++) begin
                        p = line_mem[(y % 16) * 1024 + (x % 1024)];
                        for (int k = 0; k < 3; k++) s[k] += p[8*k +: 8];
                    end
                for (int k = 0; k < 3; k++) s[k] = s[k] / cnt;
            end
            e.c0 = s[0][7:0];
            e.c1 = rgb ? s[1][7:0] : 8'd0;
            e.c2 = rgb ? s[2][7:0] : 8'd0;
            e.border = edge_pix;
            ocount++;
            e.last = (ocount >= total);
            if (e.last) begin
                row = 0; col = 0; ocount = 0;
                frame_end = 1;
            end
            pending.push_back(e);
        endfunction

        function void check_result(pix_res_t act);
            pix_res_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %h", $realtime, act);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (act.c0 !== e.c0) begin
                $display("%0t: chan0 exp %0d got %0d", $realtime, e.c0, act.c0); errors++;
            end
            if (act.c1 !== e.c1) begin
                $display("%0t: chan1 exp %0d got %0d", $realtime, e.c1, act.c1); errors++;
            end
            if (act.c2 !== e.c2) begin
                $display("%0t: chan2 exp %0d got %0d", $realtime, e.c2, act.c2); errors++;
            end
            if (act.border !== e.border) begin
                $display("%0t: passed_through exp %b got %b", $realtime, e.border,
                         act.border); errors++;
            end
            if (act.last !== e.last) begin
                $display("%0t: frame_done exp %b got %b", $realtime, e.last, act.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_cfg_we, i_valid, o_ready, i_is_filler, o_valid, i_ready;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_data;
    logic [7:0] i_chan0_in, i_chan1_in, i_chan2_in;
    logic [7:0] o_chan0_out, o_chan1_out, o_chan2_out;
    logic o_passed_through, o_frame_done;

    box_mean_filter_core i_dut (.*);

    MeanScoreboard sb;
    int  cycles;
    bit  quiet;
    bit  hold_req;
    int  n_items;

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("FAIL box_mean_filter_core");
                $finish;
            end
        end
    end

    // result side: random stall bursts, one long hold on request
    initial begin
        int stall;
        int hold;
        stall = 0;
        hold = 0;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (o_valid && i_ready)
                sb.check_result({o_chan0_out, o_chan1_out, o_chan2_out,
                                 o_passed_through, o_frame_done});
            if (hold_req) begin
                hold_req = 0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if (quiet) begin
                i_ready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else if ($urandom_range(5) == 0) begin
                stall = $urandom_range(3);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    task automatic send_beat(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2, logic fil);
        i_valid     <= 1'b1;
        i_chan0_in  <= c0;
        i_chan1_in  <= c1;
        i_chan2_in  <= c2;
        i_is_filler <= fil;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(c0, c1, c2, fil);
        if (!quiet && $urandom_range(4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic write_cfg(logic [CFG_AW-1:0] a, logic [CFG_DW-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= a;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.write_reg(a, d);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_frame(int w, int h, int rw, int rh, bit cm);
        settle();
        write_cfg(REG_FRAME_WIDTH, CFG_DW'(w));
        write_cfg(REG_FRAME_HEIGHT, CFG_DW'(h));
        write_cfg(REG_HALF_WIDTH, CFG_DW'(rw));
        write_cfg(REG_HALF_HEIGHT, CFG_DW'(rh));
        write_cfg(REG_COLOR_MODE, CFG_DW'(cm));
    endtask

    // mode 0 random, 1 all zero, 2 all full scale, 3 alternating extremes
    task automatic run_frame(int mode);
        int unsigned total;
        logic [23:0] p;
        total = sb.width_used() * sb.height_used();
        sb.frame_end = 0;
        for (int unsigned i = 0; i < total; i++) begin
            if ($urandom_range(19) == 0)
                send_beat(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
            case (mode)
                1:       p = '0;
                2:       p = '1;
                3:       p = i[0] ? '1 : '0;
                default: p = 24'($urandom);
            endcase
            send_beat(p[7:0], p[15:8], p[23:16], 1'b0);
            n_items++;
        end
        while (!sb.frame_end) begin
            send_beat(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
            n_items++;
        end
    endtask

    // first part of a frame only; the next configuration write restarts it
    task automatic run_part(int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            send_beat(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
            n_items++;
        end
    endtask

    initial begin
        sb = new();
        quiet = 0;
        hold_req = 0;
        n_items = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_chan0_in <= '0;
        i_chan1_in <= '0;
        i_chan2_in <= '0;
        i_is_filler <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fillers while idle after reset are dropped
        repeat (3) send_beat(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        // window of the reset radii on small frames, with random input gaps and result stalls
        settle();
        write_cfg(REG_FRAME_WIDTH, CFG_DW'(5));
        write_cfg(REG_FRAME_HEIGHT, CFG_DW'(4));
        run_frame(2);
        run_frame(1);
        set_frame(7, 5, 2, 1, 1);
        run_frame(3);
        run_frame(0);
        set_frame(6, 3, 0, 0, 1);
        run_frame(0);
        settle();
        write_cfg(REG_UNUSED, '1);
        run_frame(2);
        set_frame(0, 0, 7, 7, 1);
        run_frame(0);
        set_frame(2047, 1, 7, 0, 1);
        run_part(24);
        set_frame(1, 8191, 0, 7, 0);
        run_part(24);
        set_frame(16, 16, 7, 7, 1);
        run_frame(0);

        hold_req = 1;
        while (n_items < 700) begin
            if (n_items > 560) quiet = 1;
            set_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(3),
                      $urandom_range(3), 1'($urandom_range(1)));
            repeat ($urandom_range(1, 2)) run_frame($urandom_range(9) == 0 ? 3 : 0);
        end

        settle();
        if (sb.errors == 0)
            $display("PASS box_mean_filter_core");
        else
            $display("FAIL box_mean_filter_core");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/bmf_pkg.sv
rtl/bmf_ram.sv
rtl/bmf_div.sv
rtl/box_mean_filter_core.sv
test/tb.sv
